/* rtl/core/ppc_pkg.sv */
package ppc_pkg;

    localparam int TimeWidthDef   = 32;
    localparam int StampW         = 32;
    localparam int TicksW         = 16;
    localparam int LedW           = 16;
    localparam int EventW         = 3;
    localparam logic [TicksW-1:0] TimeoutReset = 16'd200;

    localparam logic [LedW-1:0] LedTop   = 16'h8000;
    localparam logic [LedW-1:0] LedLong  = 16'hFF00;
    localparam logic [LedW-1:0] LedSL    = 16'hFC00;
    localparam logic [LedW-1:0] LedLS    = 16'hFFFF;
    localparam logic [LedW-1:0] LedClear = 16'h0000;

    // classifier states, one-hot
    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,  // waiting for first press
        ST_P1       = 9'b000000010,  // first press held, timing
        ST_R1       = 9'b000000100,  // short release, waiting for second press
        ST_P1_LONG  = 9'b000001000,  // first press went long
        ST_P2_AFT_S = 9'b000010000,  // second press after short
        ST_R1_LONG  = 9'b000100000,  // released after long
        ST_SL_HOLD  = 9'b001000000,  // short-long, waiting for release
        ST_P2_AFT_L = 9'b010000000,  // second press after long
        ST_LL_HOLD  = 9'b100000000   // long-long, waiting for release
    } t_ppc_state;

    typedef enum logic [1:0] {
        EV_ON  = 2'd0,
        EV_OFF = 2'd1,
        EV_TO  = 2'd2
    } t_ppc_ev;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_S     = 3'd1,
        ACT_SS    = 3'd2,
        ACT_L     = 3'd3,
        ACT_SL    = 3'd4,
        ACT_LS    = 3'd5,
        ACT_LL    = 3'd6,
        ACT_STAMP = 3'd7
    } t_ppc_act;

    localparam logic [EventW-1:0] EVT_NONE = 3'd0;

    typedef struct packed {
        t_ppc_state next;
        t_ppc_act   act;
    } t_ppc_trans;

    typedef struct packed {
        t_ppc_state        state;
        logic              key_latched;
        logic [StampW-1:0] stamp;
        logic [LedW-1:0]   led;
        logic [EventW-1:0] pattern_event;
        logic              timed_out;
    } t_ppc_upd;

    function automatic logic ppc_watches(input t_ppc_state st);
        logic w;
        case (st)
            ST_P1, ST_R1, ST_P2_AFT_S, ST_R1_LONG, ST_P2_AFT_L: w = 1'b1;
            default: w = 1'b0;
        endcase
        return w;
    endfunction

    // transition table; a timeout only arrives in timer-watching states
    function automatic t_ppc_trans ppc_trans(input t_ppc_state st, input t_ppc_ev ev);
        t_ppc_trans t;
        t.next = ST_IDLE;
        t.act  = ACT_NONE;
        case (st)
            ST_IDLE: begin
                if (ev == EV_ON) begin
                    t.next = ST_P1;
                    t.act  = ACT_STAMP;
                end
            end
            ST_P1: begin
                case (ev)
                    EV_ON:  t.next = ST_P1;
                    EV_OFF: begin
                        t.next = ST_R1;
                        t.act  = ACT_STAMP;
                    end
                    default: t.next = ST_P1_LONG;
                endcase
            end
            ST_R1: begin
                case (ev)
                    EV_ON: begin
                        t.next = ST_P2_AFT_S;
                        t.act  = ACT_STAMP;
                    end
                    EV_OFF:  t.next = ST_R1;
                    default: t.act  = ACT_S;
                endcase
            end
            ST_P1_LONG: begin
                if (ev == EV_OFF) begin
                    t.next = ST_R1_LONG;
                    t.act  = ACT_STAMP;
                end else begin
                    t.next = ST_P1_LONG;
                end
            end
            ST_P2_AFT_S: begin
                case (ev)
                    EV_ON:   t.next = ST_P2_AFT_S;
                    EV_OFF:  t.act  = ACT_SS;
                    default: t.next = ST_SL_HOLD;
                endcase
            end
            ST_R1_LONG: begin
                case (ev)
                    EV_ON: begin
                        t.next = ST_P2_AFT_L;
                        t.act  = ACT_STAMP;
                    end
                    EV_OFF:  t.next = ST_R1_LONG;
                    default: t.act  = ACT_L;
                endcase
            end
            ST_SL_HOLD: begin
                if (ev == EV_OFF) t.act  = ACT_SL;
                else              t.next = ST_SL_HOLD;
            end
            ST_P2_AFT_L: begin
                case (ev)
                    EV_ON:   t.next = ST_P2_AFT_L;
                    EV_OFF:  t.act  = ACT_LS;
                    default: t.next = ST_LL_HOLD;
                endcase
            end
            ST_LL_HOLD: begin
                if (ev == EV_OFF) t.act  = ACT_LL;
                else              t.next = ST_LL_HOLD;
            end
            default: begin
                t.next = ST_IDLE;
                t.act  = ACT_NONE;
            end
        endcase
        return t;
    endfunction

endpackage

/* rtl/core/ppc_step.sv */
module ppc_step
    import ppc_pkg::*;
#(
    parameter int TIME_WIDTH = TimeWidthDef
) (
    input  t_ppc_state        i_state,
    input  logic              i_key_latched,
    input  logic [StampW-1:0] i_stamp,
    input  logic [LedW-1:0]   i_led,
    input  logic [TicksW-1:0] i_timeout_ticks,
    input  logic              i_key,
    input  logic [StampW-1:0] i_now,
    output t_ppc_upd          o_upd
);

    localparam int CmpW = (TIME_WIDTH > TicksW) ? TIME_WIDTH : TicksW;

    logic [TIME_WIDTH-1:0] elapsed;
    logic                  timeout_hit;
    logic                  edge_on;
    logic                  edge_off;
    logic                  has_ev;
    t_ppc_ev               ev;
    t_ppc_trans            tr;

    // elapsed time wraps at the timer width
    assign elapsed     = TIME_WIDTH'(i_now) - TIME_WIDTH'(i_stamp);
    assign timeout_hit = ppc_watches(i_state)
                       && (CmpW'(elapsed) >= CmpW'(i_timeout_ticks));
    assign edge_on     = !i_key_latched && i_key;
    assign edge_off    = i_key_latched && !i_key;
    assign has_ev      = timeout_hit || edge_on || edge_off;

    always_comb begin
        if (timeout_hit)  ev = EV_TO;
        else if (edge_on) ev = EV_ON;
        else              ev = EV_OFF;
    end

    assign tr = ppc_trans(i_state, ev);

    always_comb begin
        o_upd.state         = i_state;
        o_upd.key_latched   = i_key_latched;
        o_upd.stamp         = i_stamp;
        o_upd.led           = i_led;
        o_upd.pattern_event = EVT_NONE;
        o_upd.timed_out     = timeout_hit;
        // the switch is not sampled on a timeout poll
        if (!timeout_hit) o_upd.key_latched = i_key;
        if (has_ev) begin
            o_upd.state = tr.next;
            case (tr.act)
                ACT_S:     o_upd.led = (i_led >> 1) | LedTop;
                ACT_SS:    o_upd.led = i_led << 1;
                ACT_L:     o_upd.led = LedLong;
                ACT_SL:    o_upd.led = LedSL;
                ACT_LS:    o_upd.led = LedLS;
                ACT_LL:    o_upd.led = LedClear;
                ACT_STAMP: o_upd.stamp = i_now;
                default:   o_upd.led = i_led;
            endcase
            if (tr.act != ACT_NONE && tr.act != ACT_STAMP) begin
                o_upd.pattern_event = EventW'(tr.act);
            end
        end
    end

endmodule

/* rtl/core/press_pattern_classifier.sv */
// Each item passes through the input register and then the result register to the master side.
// Throughput: one item per cycle unless the master side stalls; the only loop is the state update.
// Reset (i_rst_n low, synchronous): classifier idle, key released, stamp and LEDs
// zero, timeout_ticks back to 200, both stream sides empty.
// Each accepted item gives exactly one result item.
module press_pattern_classifier
    import ppc_pkg::*;
#(
    parameter int TIME_WIDTH = TimeWidthDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TicksW-1:0] i_cfg_wdata,    // timeout_ticks
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [39:0]       s_axis_tdata,   // [0] key_pressed, [32:1] current_time
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata    // [15:0] led_pattern, [18:16] pattern_event,
                                              // [19] timed_out
);

    // input register
    logic              r_in_valid;
    logic              r_in_key;
    logic [StampW-1:0] r_in_time;

    // classifier state
    t_ppc_state        r_state;
    logic              r_key_latched;
    logic [StampW-1:0] r_stamp;
    logic [LedW-1:0]   r_led;
    logic [TicksW-1:0] r_timeout;

    // result register
    logic              r_out_valid;
    logic [LedW-1:0]   r_out_led;
    logic [EventW-1:0] r_out_event;
    logic              r_out_timed;

    logic              n_out_free;
    logic              n_advance;
    t_ppc_upd          upd;

    // advance the item in the input register when the result register can take it
    assign n_out_free    = !r_out_valid || m_axis_tready;
    assign n_advance     = r_in_valid && n_out_free;
    assign s_axis_tready = !r_in_valid || n_out_free;

    ppc_step #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_step (
        .i_state        (r_state),
        .i_key_latched  (r_key_latched),
        .i_stamp        (r_stamp),
        .i_led          (r_led),
        .i_timeout_ticks(r_timeout),
        .i_key          (r_in_key),
        .i_now          (r_in_time),
        .o_upd          (upd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // payload only; hold while stalled
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_key  <= s_axis_tdata[0];
            r_in_time <= s_axis_tdata[32:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TimeoutReset;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    // commit one poll's update per advancing item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_key_latched <= 1'b0;
            r_stamp       <= '0;
            r_led         <= '0;
        end else if (n_advance) begin
            r_state       <= upd.state;
            r_key_latched <= upd.key_latched;
            r_stamp       <= upd.stamp;
            r_led         <= upd.led;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_advance) begin
            r_out_led   <= upd.led;
            r_out_event <= upd.pattern_event;
            r_out_timed <= upd.timed_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_timed, r_out_event, r_out_led};

endmodule
